// File: sv/isv_pkg.sv
package isv_pkg;

    localparam int NUM_LANES = 6;
    localparam int NUM_ACCEL = 3;
    localparam int VAL_W = 24;
    localparam int LIMIT_W = 23;
    localparam int COUNT_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [VAL_W-1:0] ACCEL_LIMIT_RST = 24'd7848;
    localparam logic [VAL_W-1:0] RATE_LIMIT_RST = 24'd24500;
    localparam logic [COUNT_W-1:0] BUFFER_LIMIT_RST = 8'd20;
    localparam logic signed [VAL_W-1:0] DISCONNECT_RST = -24'sd100000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0]
    {
        REG_ACCEL_LIMIT = 2'd0,
        REG_RATE_LIMIT = 2'd1,
        REG_BUFFER_LIMIT = 2'd2,
        REG_DISCONNECT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        MODE_OFF = 2'd0,
        MODE_ON = 2'd1,
        MODE_BUF = 2'd2
    } mode_t;

    typedef enum logic [1:0]
    {
        CLS_BAD = 2'd0,
        CLS_OK = 2'd1,
        CLS_NOCONN = 2'd2
    } class_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0] accel_x;
        logic signed [VAL_W-1:0] accel_y;
        logic signed [VAL_W-1:0] accel_z;
        logic signed [VAL_W-1:0] rate_x;
        logic signed [VAL_W-1:0] rate_y;
        logic signed [VAL_W-1:0] rate_z;
    } sample_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0] out_accel_x;
        logic signed [VAL_W-1:0] out_accel_y;
        logic signed [VAL_W-1:0] out_accel_z;
        logic signed [VAL_W-1:0] out_rate_x;
        logic signed [VAL_W-1:0] out_rate_y;
        logic signed [VAL_W-1:0] out_rate_z;
        logic failure;
        logic log_enable;
        logic [1:0] sensor_state;
        logic [1:0] sample_class;
    } result_t;

    typedef struct packed
    {
        logic noconn;
        logic over;
    } lane_flags_t;

    typedef struct packed
    {
        logic [LIMIT_W-1:0] accel_limit;
        logic [LIMIT_W-1:0] rate_limit;
        logic [COUNT_W-1:0] buffer_limit;
        logic signed [VAL_W-1:0] disconnect_code;
    } cfg_t;

endpackage

// File: sv/isv_lane.sv
module isv_lane
(
    input  logic signed [isv_pkg::VAL_W-1:0]   value,
    input  logic [isv_pkg::LIMIT_W-1:0]        limit,
    input  logic signed [isv_pkg::VAL_W-1:0]   code,
    input  logic                               check_code,
    output isv_pkg::lane_flags_t               flags
);

    logic [isv_pkg::VAL_W-1:0] mag;

    always_comb
    begin
        mag = value[isv_pkg::VAL_W-1] ? (~value + 1'b1) : value;
        flags.over = mag > {1'b0, limit};
        flags.noconn = check_code && (value == code);
    end

endmodule

// File: sv/isv_ctrl.sv
module isv_ctrl
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  isv_pkg::sample_t                            sample,
    input  isv_pkg::lane_flags_t [isv_pkg::NUM_LANES-1:0] flags,
    input  logic [isv_pkg::COUNT_W-1:0]                 buffer_limit,
    output isv_pkg::result_t                            result
);

    isv_pkg::mode_t mode_reg;
    isv_pkg::mode_t mode_next;
    isv_pkg::class_t last_class_reg;
    isv_pkg::class_t cls;
    logic [isv_pkg::COUNT_W-1:0] count_reg;
    logic [isv_pkg::COUNT_W-1:0] count_next;
    logic signed [isv_pkg::VAL_W-1:0] held_reg [isv_pkg::NUM_LANES];
    logic signed [isv_pkg::VAL_W-1:0] held_next [isv_pkg::NUM_LANES];
    logic signed [isv_pkg::VAL_W-1:0] vals [isv_pkg::NUM_LANES];
    logic any_noconn;
    logic any_over;
    logic changed;
    logic over_limit;

    assign vals[0] = sample.accel_x;
    assign vals[1] = sample.accel_y;
    assign vals[2] = sample.accel_z;
    assign vals[3] = sample.rate_x;
    assign vals[4] = sample.rate_y;
    assign vals[5] = sample.rate_z;

    // merge lane findings
    always_comb
    begin
        any_noconn = 1'b0;
        any_over = 1'b0;
        for (int i = 0; i < isv_pkg::NUM_LANES; i++)
        begin
            any_noconn = any_noconn | flags[i].noconn;
            any_over = any_over | flags[i].over;
        end
        if (any_noconn)
        begin
            cls = isv_pkg::CLS_NOCONN;
        end
        else if (any_over)
        begin
            cls = isv_pkg::CLS_BAD;
        end
        else
        begin
            cls = isv_pkg::CLS_OK;
        end
        changed = cls != last_class_reg;
        over_limit = count_reg > buffer_limit;
    end

    // next state
    always_comb
    begin
        if (changed)
        begin
            mode_next = (mode_reg == isv_pkg::MODE_OFF || mode_reg == isv_pkg::MODE_BUF)
                        ? isv_pkg::MODE_ON : isv_pkg::MODE_BUF;
        end
        else
        begin
            unique case (mode_reg)
                isv_pkg::MODE_ON:  mode_next = isv_pkg::MODE_ON;
                isv_pkg::MODE_BUF: mode_next = over_limit ? isv_pkg::MODE_OFF
                                                          : isv_pkg::MODE_BUF;
                default:           mode_next = isv_pkg::MODE_OFF;
            endcase
        end
    end

    // outputs, counter and held values
    always_comb
    begin
        count_next = count_reg;
        if (!changed && mode_reg == isv_pkg::MODE_BUF)
        begin
            if (over_limit)
            begin
                count_next = '0;
            end
            else if (count_reg >= isv_pkg::COUNT_MAX - 8'd1)
            begin
                count_next = isv_pkg::COUNT_MAX;
            end
            else
            begin
                count_next = count_reg + 8'd2;
            end
        end
        else if (mode_next == isv_pkg::MODE_BUF && count_reg != isv_pkg::COUNT_MAX)
        begin
            count_next = count_reg + 8'd1;
        end

        for (int i = 0; i < isv_pkg::NUM_LANES; i++)
        begin
            unique case (mode_next)
                isv_pkg::MODE_ON:  held_next[i] = vals[i];
                isv_pkg::MODE_BUF: held_next[i] = held_reg[i];
                default:           held_next[i] = '0;
            endcase
        end

        result.out_accel_x = held_next[0];
        result.out_accel_y = held_next[1];
        result.out_accel_z = held_next[2];
        result.out_rate_x = held_next[3];
        result.out_rate_y = held_next[4];
        result.out_rate_z = held_next[5];
        result.failure = mode_next != isv_pkg::MODE_ON;
        result.log_enable = mode_next != isv_pkg::MODE_OFF;
        result.sensor_state = mode_next;
        result.sample_class = cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= isv_pkg::MODE_OFF;
            last_class_reg <= isv_pkg::CLS_BAD;
            count_reg <= '0;
            for (int i = 0; i < isv_pkg::NUM_LANES; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            mode_reg <= mode_next;
            last_class_reg <= cls;
            count_reg <= count_next;
            for (int i = 0; i < isv_pkg::NUM_LANES; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

// File: sv/imu_sample_validity_fsm.sv
// a result is registered in the output register, or in the skid entry while the output is stalled
// throughput: one sample per cycle while sample_stall is low; six lanes check all values in parallel
// a two-entry output buffer keeps input transfers going while a result waits
// reset: state not active, last class not valid, counter and held values zero,
// registers at their default limits and sentinel
module imu_sample_validity_fsm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  isv_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output isv_pkg::result_t                 result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [isv_pkg::ADDR_W-1:0]       paddr,
    input  logic [isv_pkg::DATA_W-1:0]       pwdata,
    output logic [isv_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    isv_pkg::cfg_t cfg_reg;
    isv_pkg::reg_idx_t reg_idx;
    isv_pkg::lane_flags_t [isv_pkg::NUM_LANES-1:0] flags;
    isv_pkg::result_t step_result;
    isv_pkg::result_t out_reg;
    isv_pkg::result_t out_next;
    isv_pkg::result_t skid_reg;
    isv_pkg::result_t skid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic accept;
    logic signed [isv_pkg::VAL_W-1:0] vals [isv_pkg::NUM_LANES];

    assign pready = 1'b1;
    assign reg_idx = isv_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_limit <= isv_pkg::ACCEL_LIMIT_RST[isv_pkg::LIMIT_W-1:0];
            cfg_reg.rate_limit <= isv_pkg::RATE_LIMIT_RST[isv_pkg::LIMIT_W-1:0];
            cfg_reg.buffer_limit <= isv_pkg::BUFFER_LIMIT_RST;
            cfg_reg.disconnect_code <= isv_pkg::DISCONNECT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                isv_pkg::REG_ACCEL_LIMIT:
                    cfg_reg.accel_limit <= pwdata[isv_pkg::LIMIT_W-1:0];
                isv_pkg::REG_RATE_LIMIT:
                    cfg_reg.rate_limit <= pwdata[isv_pkg::LIMIT_W-1:0];
                isv_pkg::REG_BUFFER_LIMIT:
                    cfg_reg.buffer_limit <= pwdata[isv_pkg::COUNT_W-1:0];
                default:
                    cfg_reg.disconnect_code <= signed'(pwdata[isv_pkg::VAL_W-1:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            isv_pkg::REG_ACCEL_LIMIT:
                prdata = {{(isv_pkg::DATA_W-isv_pkg::LIMIT_W){1'b0}}, cfg_reg.accel_limit};
            isv_pkg::REG_RATE_LIMIT:
                prdata = {{(isv_pkg::DATA_W-isv_pkg::LIMIT_W){1'b0}}, cfg_reg.rate_limit};
            isv_pkg::REG_BUFFER_LIMIT:
                prdata = {{(isv_pkg::DATA_W-isv_pkg::COUNT_W){1'b0}}, cfg_reg.buffer_limit};
            default:
                prdata = {{(isv_pkg::DATA_W-isv_pkg::VAL_W){1'b0}}, cfg_reg.disconnect_code};
        endcase
    end

    assign vals[0] = sample.accel_x;
    assign vals[1] = sample.accel_y;
    assign vals[2] = sample.accel_z;
    assign vals[3] = sample.rate_x;
    assign vals[4] = sample.rate_y;
    assign vals[5] = sample.rate_z;

    for (genvar g = 0; g < isv_pkg::NUM_LANES; g++)
    begin : g_lane
        isv_lane u_lane
        (
            .value      (vals[g]),
            .limit      ((g < isv_pkg::NUM_ACCEL) ? cfg_reg.accel_limit : cfg_reg.rate_limit),
            .code       (cfg_reg.disconnect_code),
            .check_code ((g < isv_pkg::NUM_ACCEL) ? 1'b1 : 1'b0),
            .flags      (flags[g])
        );
    end

    isv_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .sample       (sample),
        .flags        (flags),
        .buffer_limit (cfg_reg.buffer_limit),
        .result       (step_result)
    );

    // output buffer with skid entry
    assign sample_stall = skid_valid_reg;
    assign accept = sample_valid && !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next = skid_reg;
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_next = step_result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next = step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// File: tb/imu_sample_validity_fsm_tb.sv
`timescale 1ns / 1ps

module imu_sample_validity_fsm_tb;

    class validity_tracker;
        logic [isv_pkg::LIMIT_W-1:0] accel_limit;
        logic [isv_pkg::LIMIT_W-1:0] rate_limit;
        logic [isv_pkg::COUNT_W-1:0] buffer_limit;
        logic signed [isv_pkg::VAL_W-1:0] disconnect_code;
        isv_pkg::mode_t mode;
        isv_pkg::class_t last_cls;
        logic [isv_pkg::COUNT_W-1:0] buf_count;
        logic signed [isv_pkg::VAL_W-1:0] held [isv_pkg::NUM_LANES];
        isv_pkg::result_t outputs_due [$];
        int errors;
        int n_samples;
        int n_results;
        int n_timeouts;
        int peak_count;
        int n_class [3];

        function new();
            accel_limit = isv_pkg::ACCEL_LIMIT_RST[isv_pkg::LIMIT_W-1:0];
            rate_limit = isv_pkg::RATE_LIMIT_RST[isv_pkg::LIMIT_W-1:0];
            buffer_limit = isv_pkg::BUFFER_LIMIT_RST;
            disconnect_code = isv_pkg::DISCONNECT_RST;
            mode = isv_pkg::MODE_OFF;
            last_cls = isv_pkg::CLS_BAD;
            buf_count = '0;
            foreach (held[i])
                held[i] = '0;
            errors = 0;
            n_samples = 0;
            n_results = 0;
            n_timeouts = 0;
            peak_count = 0;
            n_class = '{0, 0, 0};
        endfunction

        function void set_reg(isv_pkg::reg_idx_t idx, logic [isv_pkg::DATA_W-1:0] val);
            case (idx)
                isv_pkg::REG_ACCEL_LIMIT: accel_limit = val[isv_pkg::LIMIT_W-1:0];
                isv_pkg::REG_RATE_LIMIT: rate_limit = val[isv_pkg::LIMIT_W-1:0];
                isv_pkg::REG_BUFFER_LIMIT: buffer_limit = val[isv_pkg::COUNT_W-1:0];
                default: disconnect_code = val[isv_pkg::VAL_W-1:0];
            endcase
        endfunction

        function logic [isv_pkg::DATA_W-1:0] reg_mask(isv_pkg::reg_idx_t idx);
            case (idx)
                isv_pkg::REG_ACCEL_LIMIT, isv_pkg::REG_RATE_LIMIT: return 32'h007f_ffff;
                isv_pkg::REG_BUFFER_LIMIT: return 32'h0000_00ff;
                default: return 32'h00ff_ffff;
            endcase
        endfunction

        function logic [isv_pkg::DATA_W-1:0] reg_value(isv_pkg::reg_idx_t idx);
            case (idx)
                isv_pkg::REG_ACCEL_LIMIT: return isv_pkg::DATA_W'(accel_limit);
                isv_pkg::REG_RATE_LIMIT: return isv_pkg::DATA_W'(rate_limit);
                isv_pkg::REG_BUFFER_LIMIT: return isv_pkg::DATA_W'(buffer_limit);
                default: return {8'h00, disconnect_code};
            endcase
        endfunction

        function int mag(logic signed [isv_pkg::VAL_W-1:0] x);
            int w;
            w = x;
            return (w < 0) ? -w : w;
        endfunction

        function void bump();
            if (buf_count < isv_pkg::COUNT_MAX)
                buf_count++;
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction

        function void note_sample(isv_pkg::sample_t s);
            logic signed [isv_pkg::VAL_W-1:0] v [isv_pkg::NUM_LANES];
            isv_pkg::class_t cls;
            isv_pkg::mode_t new_mode;
            isv_pkg::result_t r;
            v[0] = s.accel_x;
            v[1] = s.accel_y;
            v[2] = s.accel_z;
            v[3] = s.rate_x;
            v[4] = s.rate_y;
            v[5] = s.rate_z;

            if (v[0] == disconnect_code || v[1] == disconnect_code || v[2] == disconnect_code)
                cls = isv_pkg::CLS_NOCONN;
            else if (mag(v[0]) > accel_limit || mag(v[1]) > accel_limit
                     || mag(v[2]) > accel_limit)
                cls = isv_pkg::CLS_BAD;
            else if (mag(v[3]) > rate_limit || mag(v[4]) > rate_limit
                     || mag(v[5]) > rate_limit)
                cls = isv_pkg::CLS_BAD;
            else
                cls = isv_pkg::CLS_OK;

            if (cls != last_cls)
                new_mode = (mode == isv_pkg::MODE_ON) ? isv_pkg::MODE_BUF : isv_pkg::MODE_ON;
            else if (mode == isv_pkg::MODE_ON)
                new_mode = isv_pkg::MODE_ON;
            else if (mode == isv_pkg::MODE_BUF)
            begin
                if (buf_count > buffer_limit)
                begin
                    new_mode = isv_pkg::MODE_OFF;
                    buf_count = '0;
                    n_timeouts++;
                end
                else
                begin
                    new_mode = isv_pkg::MODE_BUF;
                    bump();
                end
            end
            else
                new_mode = isv_pkg::MODE_OFF;

            if (new_mode == isv_pkg::MODE_ON)
                held = v;
            else if (new_mode == isv_pkg::MODE_BUF)
                bump();
            else
                foreach (held[i])
                    held[i] = '0;

            mode = new_mode;
            last_cls = cls;
            if (buf_count > peak_count)
                peak_count = buf_count;
            n_class[cls]++;
            n_samples++;

            r.out_accel_x = held[0];
            r.out_accel_y = held[1];
            r.out_accel_z = held[2];
            r.out_rate_x = held[3];
            r.out_rate_y = held[4];
            r.out_rate_z = held[5];
            r.failure = (new_mode != isv_pkg::MODE_ON);
            r.log_enable = (new_mode != isv_pkg::MODE_OFF);
            r.sensor_state = new_mode;
            r.sample_class = cls;
            outputs_due.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(isv_pkg::result_t got);
            isv_pkg::result_t want;
            if (outputs_due.size() == 0)
            begin
                $error("result transfer with no sample outstanding");
                errors++;
                return;
            end
            want = outputs_due.pop_front();
            n_results++;
            compare_field("out_accel_x", want.out_accel_x, got.out_accel_x);
            compare_field("out_accel_y", want.out_accel_y, got.out_accel_y);
            compare_field("out_accel_z", want.out_accel_z, got.out_accel_z);
            compare_field("out_rate_x", want.out_rate_x, got.out_rate_x);
            compare_field("out_rate_y", want.out_rate_y, got.out_rate_y);
            compare_field("out_rate_z", want.out_rate_z, got.out_rate_z);
            compare_field("failure", want.failure, got.failure);
            compare_field("log_enable", want.log_enable, got.log_enable);
            compare_field("sensor_state", want.sensor_state, got.sensor_state);
            compare_field("sample_class", want.sample_class, got.sample_class);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    isv_pkg::sample_t sample;
    logic result_valid;
    logic result_stall;
    isv_pkg::result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [isv_pkg::ADDR_W-1:0] paddr;
    logic [isv_pkg::DATA_W-1:0] pwdata;
    logic [isv_pkg::DATA_W-1:0] prdata;
    logic pready;

    validity_tracker sb;
    int sender_idle_pct;
    int stall_pct;

    imu_sample_validity_fsm u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    // result side: check at the edge, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic isv_pkg::sample_t mk(int ax, int ay, int az, int rx, int ry, int rz);
        isv_pkg::sample_t s;
        s.accel_x = isv_pkg::VAL_W'(ax);
        s.accel_y = isv_pkg::VAL_W'(ay);
        s.accel_z = isv_pkg::VAL_W'(az);
        s.rate_x = isv_pkg::VAL_W'(rx);
        s.rate_y = isv_pkg::VAL_W'(ry);
        s.rate_z = isv_pkg::VAL_W'(rz);
        return s;
    endfunction

    function automatic int in_limit(int unsigned lim);
        int unsigned m;
        m = ($urandom_range(3) == 0) ? lim : $urandom_range(lim);
        return $urandom_range(1) ? -int'(m) : int'(m);
    endfunction

    function automatic int over_limit(int unsigned lim);
        int unsigned m;
        m = ($urandom_range(3) == 0) ? lim + 1 : $urandom_range(8388608, lim + 1);
        if (m == 8388608)
            return -8388608;
        return $urandom_range(1) ? -int'(m) : int'(m);
    endfunction

    function automatic isv_pkg::sample_t make_sample(isv_pkg::class_t want);
        int lane [isv_pkg::NUM_LANES];
        int k;
        for (k = 0; k < isv_pkg::NUM_LANES; k++)
            lane[k] = in_limit((k < isv_pkg::NUM_ACCEL) ? sb.accel_limit : sb.rate_limit);
        if (want == isv_pkg::CLS_BAD)
        begin
            k = $urandom_range(isv_pkg::NUM_LANES - 1);
            lane[k] = over_limit((k < isv_pkg::NUM_ACCEL) ? sb.accel_limit : sb.rate_limit);
        end
        else if (want == isv_pkg::CLS_NOCONN)
        begin
            k = $urandom_range(isv_pkg::NUM_ACCEL - 1);
            lane[k] = sb.disconnect_code;
        end
        return mk(lane[0], lane[1], lane[2], lane[3], lane[4], lane[5]);
    endfunction

    function automatic isv_pkg::sample_t noise_sample();
        return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic push_sample(input isv_pkg::sample_t s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(s);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic reg_write(input isv_pkg::reg_idx_t idx,
                             input logic [isv_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input isv_pkg::reg_idx_t idx,
                            output logic [isv_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        val = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned al, input int unsigned rl,
                                  input int unsigned bl, input int dc);
        logic [isv_pkg::DATA_W-1:0] vals [4];
        logic [isv_pkg::DATA_W-1:0] got;
        isv_pkg::reg_idx_t idx;
        vals[0] = al;
        vals[1] = rl;
        vals[2] = bl;
        vals[3] = dc;
        drain();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            idx = isv_pkg::reg_idx_t'(i);
            reg_write(idx, vals[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            idx = isv_pkg::reg_idx_t'(i);
            reg_read(idx, got);
            if ((got & sb.reg_mask(idx)) !== sb.reg_value(idx))
            begin
                $error("%s expected %0h got %0h", idx.name(), sb.reg_value(idx),
                       got & sb.reg_mask(idx));
                sb.errors++;
            end
        end
    endtask

    // sit in buffering until the counter passes the limit, then toggle
    // the class so the counter climbs to saturation without a timeout
    task automatic climb_counter();
        while (sb.mode != isv_pkg::MODE_BUF)
            push_sample(make_sample((sb.last_cls == isv_pkg::CLS_OK) ? isv_pkg::CLS_BAD
                                                                      : isv_pkg::CLS_OK));
        while (sb.mode == isv_pkg::MODE_BUF && sb.buf_count <= sb.buffer_limit)
            push_sample(make_sample(sb.last_cls));
        repeat (24)
            push_sample(make_sample((sb.last_cls == isv_pkg::CLS_OK) ? isv_pkg::CLS_BAD
                                                                      : isv_pkg::CLS_OK));
    endtask

    task automatic run_random(input int target, input bit climb);
        int done;
        int n;
        int cap;
        int roll;
        isv_pkg::class_t c0;
        isv_pkg::class_t c1;
        bit paused;
        done = 0;
        paused = 1'b0;
        if (climb)
            climb_counter();
        while (done < target)
        begin
            roll = $urandom_range(99);
            c0 = isv_pkg::class_t'($urandom_range(2));
            c1 = isv_pkg::class_t'((int'(c0) + $urandom_range(2, 1)) % 3);
            if (roll < 45)
            begin
                cap = int'(sb.buffer_limit) / 2 + 4;
                n = $urandom_range((cap > 140) ? 140 : cap, 1);
                repeat (n)
                    push_sample(make_sample(c0));
            end
            else if (roll < 80)
            begin
                n = $urandom_range(24, 2);
                for (int k = 0; k < n; k++)
                    push_sample(make_sample((k % 2) ? c1 : c0));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_sample(noise_sample());
            end
            done += n;
            if (!paused && done >= target / 2)
            begin
                paused = 1'b1;
                drain();
            end
        end
    endtask

    task automatic run_phase(input int unsigned al, input int unsigned rl,
                             input int unsigned bl, input int dc,
                             input int idle, input int stall, input bit climb);
        apply_settings(al, rl, bl, dc);
        sender_idle_pct = idle;
        stall_pct = stall;
        run_random(170, climb);
    endtask

    initial
    begin
        #1_000_000;
        $display("imu_sample_validity_fsm test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sender_idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples at the reset limits
        push_sample(mk(0, 0, 0, 0, 0, 0));
        push_sample(mk(7848, -7848, 7848, 24500, -24500, 24500));
        push_sample(mk(7849, 0, 0, 0, 0, 0));
        push_sample(mk(0, 0, 0, 0, 0, -24501));
        push_sample(mk(0, -100000, 0, 0, 0, 0));
        // steady no connection while active passes values through
        push_sample(mk(5, -3, -100000, 100, -100, 7));
        push_sample(mk(-100000, 0, 0, 0, 0, 0));
        // sentinel on a rate is only an oversize rate
        push_sample(mk(0, 0, 0, -100000, 0, 0));
        push_sample(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        push_sample(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
        push_sample(mk(-7848, 7848, -7848, -24500, 24500, -24500));
        push_sample(mk(-7849, 0, 0, 0, 0, 0));
        push_sample(mk('h555555, 'h555555, 'h555555, 'h555555, 'h555555, 'h555555));
        push_sample(mk('haaaaaa, 'haaaaaa, 'haaaaaa, 'haaaaaa, 'haaaaaa, 'haaaaaa));
        push_sample(mk(-1, -1, -1, -1, -1, -1));
        push_sample(mk(0, 0, 0, 24501, 0, 0));
        push_sample(mk(1, 1, 1, 1, 1, 1));
        repeat (8)
            push_sample(mk(0, 7849, 0, 0, 0, 0));

        run_phase(7848, 24500, 20, -100000, 0, 0, 1'b0);
        run_phase(0, 0, 0, -8388608, 88, 0, 1'b0);
        run_phase(8388607, 8388607, 250, 8388607, 0, 88, 1'b0);
        run_phase(1000, 3000, 250, -8388608, 9, 9, 1'b1);
        run_phase($urandom_range(20000), $urandom_range(40000), $urandom_range(30),
                  $urandom_range(1) ? in_limit(2000) : int'($urandom), 0, 0, 1'b0);
        run_phase($urandom_range(20000), $urandom_range(40000), $urandom_range(30),
                  $urandom_range(1) ? in_limit(2000) : int'($urandom), 88, 0, 1'b0);
        run_phase($urandom_range(20000), $urandom_range(40000), $urandom_range(30),
                  $urandom_range(1) ? in_limit(2000) : int'($urandom), 0, 88, 1'b0);
        run_phase($urandom_range(20000), $urandom_range(40000), $urandom_range(30),
                  $urandom_range(1) ? in_limit(2000) : int'($urandom), 9, 9, 1'b0);

        drain();
        repeat (8) @(posedge clk);

        $display("samples: %0d (%0d valid, %0d not valid, %0d no connection), results: %0d",
                 sb.n_samples, sb.n_class[isv_pkg::CLS_OK], sb.n_class[isv_pkg::CLS_BAD],
                 sb.n_class[isv_pkg::CLS_NOCONN], sb.n_results);
        $display("register settings: 8, buffering timeouts: %0d, counter peak: %0d",
                 sb.n_timeouts, sb.peak_count);
        if (sb.errors == 0)
            $display("imu_sample_validity_fsm test passed");
        else
            $display("imu_sample_validity_fsm test failed");
        $finish;
    end

endmodule
